### hw/rtl/bgrm_pkg.sv
// Shared types and constants for the greedy rectangle cover block.
// Used by bgrm_ctrl, bgrm_dp and bitmap_greedy_rectangle_merge.
package bgrm_pkg;

    localparam int DEF_MAX_COLS = 8;
    localparam int DEF_MAX_ROWS = 8;

    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int COORD_W   = 8;
    localparam int RX_W      = 3;
    localparam int RY_W      = 3;
    localparam int RW_W      = 4;
    localparam int RH_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLLISION   = 2'd2;

    localparam logic [CFG_W-1:0] GRID_WIDTH_RESET  = 4'd8;
    localparam logic [CFG_W-1:0] GRID_HEIGHT_RESET = 4'd8;
    localparam logic             COLLISION_RESET   = 1'b1;

    localparam logic FUNC_CELL  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_GROW_R,
        ST_GROW_D,
        ST_MARK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic start_scan;
        logic step;
        logic begin_rect;
        logic grow_r;
        logic begin_down;
        logic grow_d;
        logic sel_down;
        logic mark;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic rebuild;
        logic cell_free;
        logic can_right;
        logic can_down;
        logic at_end;
    } t_dp_stat;

endpackage

### hw/rtl/bgrm_ctrl.sv
// Sequencer for the rectangle scan: request accept, scan, grow, mark, finish.
// Depends on bgrm_pkg; drives bgrm_dp through t_dp_cmd.
module bgrm_ctrl import bgrm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_start && (r_state == ST_IDLE);
    assign o_busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_stat.rebuild) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_stat.cell_free)   n_state = ST_GROW_R;
                else if (i_stat.at_end) n_state = ST_DONE;
            end
            ST_GROW_R: begin
                if (!i_stat.can_right) n_state = ST_GROW_D;
            end
            ST_GROW_D: begin
                if (!i_stat.can_down) n_state = ST_MARK;
            end
            ST_MARK: begin
                n_state = i_stat.at_end ? ST_DONE : ST_SCAN;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept     = accept;
                o_cmd.start_scan = accept && i_stat.rebuild;
            end
            ST_SCAN: begin
                o_cmd.begin_rect = i_stat.cell_free;
                o_cmd.step       = !i_stat.cell_free && !i_stat.at_end;
            end
            ST_GROW_R: begin
                o_cmd.grow_r     = i_stat.can_right;
                o_cmd.begin_down = !i_stat.can_right;
            end
            ST_GROW_D: begin
                o_cmd.sel_down = 1'b1;
                o_cmd.grow_d   = i_stat.can_down;
            end
            ST_MARK: begin
                o_cmd.mark = 1'b1;
                o_cmd.step = !i_stat.at_end;
            end
            ST_DONE: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### hw/rtl/bgrm_dp.sv
// Datapath: occupancy and covered grids, scan position, rectangle growth, result regs.
// Depends on bgrm_pkg; controlled by bgrm_ctrl through t_dp_cmd.
module bgrm_dp import bgrm_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [CFG_W-1:0]   i_grid_width,
    input  logic [CFG_W-1:0]   i_grid_height,
    input  logic               i_collision_en,
    input  logic               i_func,
    input  logic [COORD_W-1:0] i_cell_x,
    input  logic [COORD_W-1:0] i_cell_y,
    input  logic               i_active,
    output logic               o_strobe,
    output logic               o_rect_valid,
    output logic [RX_W-1:0]    o_rect_x,
    output logic [RY_W-1:0]    o_rect_y,
    output logic [RW_W-1:0]    o_rect_w,
    output logic [RH_W-1:0]    o_rect_h,
    output logic               o_last
);

    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);

    logic [MAX_COLS-1:0] r_occ [MAX_ROWS];
    logic [MAX_COLS-1:0] r_cov [MAX_ROWS];

    logic [CW-1:0] r_x, r_w, r_pend_x, r_pend_w;
    logic [RW-1:0] r_y, r_h, r_pend_y, r_pend_h;
    logic          r_pend_vld;

    logic            r_strobe, r_valid, r_last;
    logic [RX_W-1:0] r_out_x;
    logic [RY_W-1:0] r_out_y;
    logic [RW_W-1:0] r_out_w;
    logic [RH_W-1:0] r_out_h;

    logic [CW-1:0]       eff_w, pos_r;
    logic [RW-1:0]       eff_h, rd_row, row_dn, row_top;
    logic                x_ok, y_ok, row_end;
    logic [MAX_COLS-1:0] cmask, row_free, sh_x, sh_r, low_m, rmask;

    assign eff_w = (i_grid_width > CFG_W'(MAX_COLS)) ? CW'(MAX_COLS) : i_grid_width[CW-1:0];
    assign eff_h = (i_grid_height > CFG_W'(MAX_ROWS)) ? RW'(MAX_ROWS)
                                                       : i_grid_height[RW-1:0];

    assign x_ok  = !i_cell_x[COORD_W-1] && ({1'b0, i_cell_x[COORD_W-2:0]} < COORD_W'(eff_w));
    assign y_ok  = !i_cell_y[COORD_W-1] && ({1'b0, i_cell_y[COORD_W-2:0]} < COORD_W'(eff_h));
    assign cmask = MAX_COLS'(1) << i_cell_x[COORD_W-2:0];

    assign row_dn = r_y + r_h;
    assign rd_row = i_cmd.sel_down ? row_dn : r_y;
    assign pos_r  = r_x + r_w;

    always_comb begin
        row_free = '0;
        for (int i = 0; i < MAX_ROWS; i++) begin
            if (RW'(i) == rd_row) row_free = r_occ[i] & ~r_cov[i];
        end
    end

    assign sh_x  = row_free >> r_x;
    assign sh_r  = row_free >> pos_r;
    assign low_m = ~({MAX_COLS{1'b1}} << r_w);
    assign rmask = low_m << r_x;

    assign row_end = (r_x == eff_w - CW'(1));
    assign row_top = eff_h - RW'(1);

    assign o_stat.rebuild   = (i_func == FUNC_CELL) && x_ok && y_ok && i_collision_en;
    assign o_stat.cell_free = sh_x[0];
    assign o_stat.can_right = (pos_r < eff_w) && sh_r[0];
    assign o_stat.can_down  = (row_dn < eff_h) && ((row_free & rmask) == rmask);
    assign o_stat.at_end    = row_end && (r_y == row_top);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ROWS; i++) begin
                r_occ[i] <= '0;
                r_cov[i] <= '0;
            end
        end else begin
            for (int i = 0; i < MAX_ROWS; i++) begin
                if (i_cmd.accept) begin
                    if (i_func == FUNC_CLEAR) begin
                        r_occ[i] <= '0;
                    end else if (x_ok && y_ok && (i_cell_y[COORD_W-2:0] == (COORD_W-1)'(i))) begin
                        r_occ[i] <= i_active ? (r_occ[i] | cmask) : (r_occ[i] & ~cmask);
                    end
                end
                if (i_cmd.start_scan) begin
                    r_cov[i] <= '0;
                end else if (i_cmd.mark && (RW'(i) >= r_y) && (RW'(i) < row_dn)) begin
                    r_cov[i] <= r_cov[i] | rmask;
                end
            end
        end
    end

    // scan position and rectangle extent
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_scan) begin
            r_x <= '0;
            r_y <= '0;
        end else if (i_cmd.step) begin
            if (row_end) begin
                r_x <= '0;
                r_y <= r_y + RW'(1);
            end else begin
                r_x <= r_x + CW'(1);
            end
        end
        if (i_cmd.begin_rect) r_w <= CW'(1);
        else if (i_cmd.grow_r) r_w <= r_w + CW'(1);
        if (i_cmd.begin_down) r_h <= RW'(1);
        else if (i_cmd.grow_d) r_h <= r_h + RW'(1);
        if (i_cmd.mark) begin
            r_pend_x <= r_x;
            r_pend_y <= r_y;
            r_pend_w <= r_w;
            r_pend_h <= r_h;
        end
    end

    // one rectangle is held back so the last flag is known when it goes out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.mark && r_pend_vld) || i_cmd.finish;
            if (i_cmd.start_scan) r_pend_vld <= 1'b0;
            else if (i_cmd.mark)  r_pend_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mark || i_cmd.finish) begin
            r_valid <= r_pend_vld;
            r_last  <= i_cmd.finish;
            r_out_x <= r_pend_vld ? RX_W'(r_pend_x) : '0;
            r_out_y <= r_pend_vld ? RY_W'(r_pend_y) : '0;
            r_out_w <= r_pend_vld ? RW_W'(r_pend_w) : '0;
            r_out_h <= r_pend_vld ? RH_W'(r_pend_h) : '0;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_rect_valid = r_valid;
    assign o_rect_x     = r_out_x;
    assign o_rect_y     = r_out_y;
    assign o_rect_w     = r_out_w;
    assign o_rect_h     = r_out_h;
    assign o_last       = r_last;

endmodule

### hw/rtl/bitmap_greedy_rectangle_merge.sv
// Top level of the greedy rectangle cover: configuration registers, sequencer, datapath.
// Depends on bgrm_pkg, bgrm_ctrl and bgrm_dp.
//
// A request (start high while busy is low) edits one cell or clears the grid. A clear,
// an ignored cell or a write with collision off runs no rebuild. A rebuild is run by
// the sequencer one cell check per cycle while it scans; growing and marking each
// rectangle found holds the scan. Each result is shown for one cycle with o_strobe and
// must be taken then; results of one rebuild come in scan order, the final one with
// o_last set, and an empty grid gives one result with o_rect_valid low. The next
// request is taken in the cycle of the final result.
module bitmap_greedy_rectangle_merge import bgrm_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_func,
    input  logic [COORD_W-1:0]   i_cell_x,
    input  logic [COORD_W-1:0]   i_cell_y,
    input  logic                 i_active,
    output logic                 o_strobe,
    output logic                 o_rect_valid,
    output logic [RX_W-1:0]      o_rect_x,
    output logic [RY_W-1:0]      o_rect_y,
    output logic [RW_W-1:0]      o_rect_w,
    output logic [RH_W-1:0]      o_rect_h,
    output logic                 o_last
);

    logic [CFG_W-1:0] r_grid_width, r_grid_height;
    logic             r_collision_en;
    t_dp_cmd          cmd;
    t_dp_stat         stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width   <= GRID_WIDTH_RESET;
            r_grid_height  <= GRID_HEIGHT_RESET;
            r_collision_en <= COLLISION_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_GRID_WIDTH:  r_grid_width   <= i_cfg_data;
                CFG_IDX_GRID_HEIGHT: r_grid_height  <= i_cfg_data;
                CFG_IDX_COLLISION:   r_collision_en <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    bgrm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    bgrm_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_grid_width   (r_grid_width),
        .i_grid_height  (r_grid_height),
        .i_collision_en (r_collision_en),
        .i_func         (i_func),
        .i_cell_x       (i_cell_x),
        .i_cell_y       (i_cell_y),
        .i_active       (i_active),
        .o_strobe       (o_strobe),
        .o_rect_valid   (o_rect_valid),
        .o_rect_x       (o_rect_x),
        .o_rect_y       (o_rect_y),
        .o_rect_w       (o_rect_w),
        .o_rect_h       (o_rect_h),
        .o_last         (o_last)
    );

endmodule

### sim/rect_cover_checker.sv
// Checker for bitmap_greedy_rectangle_merge: watches the config port, requests and results,
// predicts the greedy rectangle cover and compares every result in order.
// Depends on bgrm_pkg.
`timescale 1ns / 1ps

module rect_cover_checker import bgrm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic                 i_func,
    input  logic [COORD_W-1:0]   i_cell_x,
    input  logic [COORD_W-1:0]   i_cell_y,
    input  logic                 i_active,
    input  logic                 i_strobe,
    input  logic                 i_rect_valid,
    input  logic [RX_W-1:0]      i_rect_x,
    input  logic [RY_W-1:0]      i_rect_y,
    input  logic [RW_W-1:0]      i_rect_w,
    input  logic [RH_W-1:0]      i_rect_h,
    input  logic                 i_last,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_rects,
    output int                   o_empties
);

    typedef struct packed {
        logic            valid;
        logic [RX_W-1:0] x;
        logic [RY_W-1:0] y;
        logic [RW_W-1:0] w;
        logic [RH_W-1:0] h;
        logic            last;
    } t_rect;

    t_rect      expected_rects[$];
    logic [7:0] occupancy[8];
    logic [7:0] covered[8];
    logic [3:0] grid_w;
    logic [3:0] grid_h;
    logic       collide;
    int         mismatches;
    int         rect_count;
    int         empty_count;

    function automatic int cols_in_use();
        return (grid_w > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(grid_w);
    endfunction

    function automatic int rows_in_use();
        return (grid_h > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(grid_h);
    endfunction

    function automatic bit cell_open(int c, int r);
        return occupancy[r][c] && !covered[r][c];
    endfunction

    function automatic void enqueue_rect(input t_rect rect);
        expected_rects.insert(expected_rects.size(), rect);
    endfunction

    task automatic predict_cover();
        int    ew;
        int    eh;
        int    w;
        int    h;
        int    found;
        bit    grow;
        bit    held;
        t_rect held_rect;
        ew = cols_in_use();
        eh = rows_in_use();
        found = 0;
        held = 1'b0;
        held_rect = '0;
        for (int r = 0; r < 8; r++) covered[r] = '0;
        for (int y = 0; y < eh; y++) begin
            for (int x = 0; x < ew; x++) begin
                if (!cell_open(x, y)) continue;
                w = 1;
                while (x + w < ew && cell_open(x + w, y)) w++;
                h = 1;
                while (y + h < eh) begin
                    grow = 1'b1;
                    for (int c = x; c < x + w; c++)
                        if (!cell_open(c, y + h)) grow = 1'b0;
                    if (!grow) break;
                    h++;
                end
                for (int r = y; r < y + h; r++)
                    for (int c = x; c < x + w; c++)
                        covered[r][c] = 1'b1;
                if (found < 32) begin
                    if (held) enqueue_rect(held_rect);
                    held_rect = '{1'b1, RX_W'(x), RY_W'(y), RW_W'(w), RH_W'(h), 1'b0};
                    held = 1'b1;
                    found++;
                end
            end
        end
        if (held) begin
            held_rect.last = 1'b1;
        end else begin
            held_rect = '{1'b0, '0, '0, '0, '0, 1'b1};
        end
        enqueue_rect(held_rect);
    endtask

    always @(posedge i_clk) begin
        t_rect got;
        t_rect want;
        if (!i_rst_n) begin
            expected_rects.delete();
            for (int r = 0; r < 8; r++) occupancy[r] = '0;
            grid_w = GRID_WIDTH_RESET;
            grid_h = GRID_HEIGHT_RESET;
            collide = COLLISION_RESET;
            mismatches = 0;
            rect_count = 0;
            empty_count = 0;
        end else begin
            if (i_strobe) begin
                got = '{i_rect_valid, i_rect_x, i_rect_y, i_rect_w, i_rect_h, i_last};
                if (expected_rects.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result with no request pending (expected none)", $time);
                        $display("  actual   v=%0b x=%0d y=%0d w=%0d h=%0d last=%0b",
                                 got.valid, got.x, got.y, got.w, got.h, got.last);
                    end
                end else begin
                    want = expected_rects.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: result mismatch", $time);
                            $display("  expected v=%0b x=%0d y=%0d w=%0d h=%0d last=%0b",
                                     want.valid, want.x, want.y, want.w, want.h, want.last);
                            $display("  actual   v=%0b x=%0d y=%0d w=%0d h=%0d last=%0b",
                                     got.valid, got.x, got.y, got.w, got.h, got.last);
                        end
                    end
                    if (want.valid) rect_count++;
                    else empty_count++;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IDX_GRID_WIDTH:  grid_w = i_cfg_data;
                    CFG_IDX_GRID_HEIGHT: grid_h = i_cfg_data;
                    CFG_IDX_COLLISION:   collide = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                if (i_func == FUNC_CLEAR) begin
                    for (int r = 0; r < 8; r++) occupancy[r] = '0;
                end else if (!i_cell_x[7] && !i_cell_y[7] &&
                             int'(i_cell_x) < cols_in_use() &&
                             int'(i_cell_y) < rows_in_use()) begin
                    occupancy[i_cell_y[2:0]][i_cell_x[2:0]] = i_active;
                    if (collide) predict_cover();
                end
            end
        end
        o_errors  <= mismatches;
        o_pending <= expected_rects.size();
        o_rects   <= rect_count;
        o_empties <= empty_count;
    end

endmodule

### sim/testbench.sv
// Top of the testbench for bitmap_greedy_rectangle_merge: clock, reset, directed and random
// cell edits, register settings and the verdict. Depends on bgrm_pkg and rect_cover_checker.
`timescale 1ns / 1ps

module testbench;
    import bgrm_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_func = FUNC_CELL;
    logic [COORD_W-1:0]   i_cell_x = '0;
    logic [COORD_W-1:0]   i_cell_y = '0;
    logic                 i_active = 1'b0;
    logic                 o_strobe;
    logic                 o_rect_valid;
    logic [RX_W-1:0]      o_rect_x;
    logic [RY_W-1:0]      o_rect_y;
    logic [RW_W-1:0]      o_rect_w;
    logic [RH_W-1:0]      o_rect_h;
    logic                 o_last;

    int errors;
    int pending;
    int rects_seen;
    int empties_seen;
    int idle_pct;
    int cur_w;
    int cur_h;
    int requests_sent;
    int random_sent;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bitmap_greedy_rectangle_merge dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_cell_x     (i_cell_x),
        .i_cell_y     (i_cell_y),
        .i_active     (i_active),
        .o_strobe     (o_strobe),
        .o_rect_valid (o_rect_valid),
        .o_rect_x     (o_rect_x),
        .o_rect_y     (o_rect_y),
        .o_rect_w     (o_rect_w),
        .o_rect_h     (o_rect_h),
        .o_last       (o_last)
    );

    rect_cover_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_start      (start),
        .i_busy       (busy),
        .i_func       (i_func),
        .i_cell_x     (i_cell_x),
        .i_cell_y     (i_cell_y),
        .i_active     (i_active),
        .i_strobe     (o_strobe),
        .i_rect_valid (o_rect_valid),
        .i_rect_x     (o_rect_x),
        .i_rect_y     (o_rect_y),
        .i_rect_w     (o_rect_w),
        .i_rect_h     (o_rect_h),
        .i_last       (o_last),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_rects      (rects_seen),
        .o_empties    (empties_seen)
    );

    task automatic issue_request(input logic f, input logic [7:0] x, input logic [7:0] y,
                                 input logic a);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_func   <= f;
        i_cell_x <= x;
        i_cell_y <= y;
        i_active <= a;
        do @(posedge i_clk); while (busy);
        requests_sent++;
    endtask

    // stop requesting until every predicted rectangle is out and the block is idle
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [3:0] w, input logic [3:0] h, input logic c);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_GRID_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_IDX_GRID_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_IDX_COLLISION;
        i_cfg_data <= {3'b000, c};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_w = (w > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(w);
        cur_h = (h > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(h);
    endtask

    // mostly in-range edits; some clears and out-of-range noise; out-of-range cell edits are not counted
    task automatic random_edits(input int target);
        int         done;
        int         pick;
        logic       f;
        logic       a;
        logic [7:0] x;
        logic [7:0] y;
        bit         ignored;
        done = 0;
        while (done < target) begin
            pick = $urandom_range(99);
            f = (pick < 5) ? FUNC_CLEAR : FUNC_CELL;
            a = ($urandom_range(99) < 65);
            if (pick < 5 || pick >= 85) begin
                x = 8'($urandom_range(255));
                y = 8'($urandom_range(255));
            end else begin
                x = 8'($urandom_range(cur_w - 1));
                y = 8'($urandom_range(cur_h - 1));
            end
            ignored = (f == FUNC_CELL) && (x[7] || y[7] || x >= cur_w || y >= cur_h);
            issue_request(f, x, y, a);
            random_sent++;
            if (!ignored) done++;
            if ($urandom_range(99) < 3) drain();
        end
    endtask

    initial begin
        idle_pct = 37;
        cur_w = DEF_MAX_COLS;
        cur_h = DEF_MAX_ROWS;
        requests_sent = 0;
        random_sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: clear, empty grid, growth right and down, out-of-range coordinates
        issue_request(FUNC_CLEAR, 8'hFF, 8'h80, 1'b1);
        issue_request(FUNC_CELL, 8'd0, 8'd0, 1'b0);
        issue_request(FUNC_CELL, 8'd0, 8'd0, 1'b1);
        issue_request(FUNC_CELL, 8'd7, 8'd7, 1'b1);
        issue_request(FUNC_CELL, 8'd1, 8'd0, 1'b1);
        issue_request(FUNC_CELL, 8'd0, 8'd1, 1'b1);
        issue_request(FUNC_CELL, 8'd1, 8'd1, 1'b1);
        issue_request(FUNC_CELL, 8'hFF, 8'd0, 1'b1);
        issue_request(FUNC_CELL, 8'd0, 8'h80, 1'b1);
        issue_request(FUNC_CELL, 8'd8, 8'd0, 1'b1);
        issue_request(FUNC_CELL, 8'd0, 8'd8, 1'b1);
        issue_request(FUNC_CELL, 8'd127, 8'd127, 1'b1);
        issue_request(FUNC_CELL, 8'd7, 8'd0, 1'b1);
        issue_request(FUNC_CLEAR, 8'd0, 8'd0, 1'b0);
        issue_request(FUNC_CELL, 8'd3, 8'd3, 1'b0);

        // registers above the maximum clamp to it
        write_config(4'd15, 4'd15, 1'b1);
        issue_request(FUNC_CELL, 8'd7, 8'd7, 1'b1);
        issue_request(FUNC_CELL, 8'd6, 8'd7, 1'b1);
        // one cell in use; cells outside keep their value
        write_config(4'd1, 4'd1, 1'b1);
        issue_request(FUNC_CELL, 8'd0, 8'd0, 1'b1);
        issue_request(FUNC_CELL, 8'd1, 8'd0, 1'b1);
        // zero size: every cell edit is dropped
        write_config(4'd0, 4'd0, 1'b1);
        issue_request(FUNC_CELL, 8'd0, 8'd0, 1'b0);
        // collision off: cells are written silently
        write_config(4'd8, 4'd8, 1'b0);
        issue_request(FUNC_CELL, 8'd2, 8'd2, 1'b1);
        issue_request(FUNC_CELL, 8'd3, 8'd2, 1'b1);
        write_config(4'd8, 4'd8, 1'b1);
        issue_request(FUNC_CELL, 8'd4, 8'd4, 1'b0);

        random_edits(28);
        idle_pct = 51;
        write_config(4'd3, 4'd5, 1'b1);
        random_edits(18);
        write_config(4'd15, 4'd8, 1'b0);
        random_edits(8);
        idle_pct = 0;
        write_config(4'd8, 4'd15, 1'b1);
        random_edits(20);

        drain();
        repeat (20) @(posedge i_clk);
        $display("Ran %0d requests (%0d random) across several register settings,",
                 requests_sent, random_sent);
        $display("checking %0d rectangles and %0d empty-grid results.", rects_seen,
                 empties_seen);
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
